// ----- sv/tpe_pkg.sv -----
// Package with the types and constants of the TCP payload extractor.
`default_nettype none

package tpe_pkg;

  // Frame parse phase, one-hot coded.
  typedef enum logic [2:0] {
    PHASE_HEADER  = 3'b001,
    PHASE_PAYLOAD = 3'b010,
    PHASE_DROP    = 3'b100
  } phase_e;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_ETHERTYPE = 1'b0,
    REG_PROTOCOL  = 1'b1
  } reg_idx_e;

  localparam int unsigned POS_W = 17;

  localparam logic [POS_W-1:0] POS_MAX          = '1;
  localparam logic [POS_W-1:0] ETH_HDR_BYTES    = 17'd14;
  localparam logic [POS_W-1:0] POS_ETYPE_HI     = 17'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO     = 17'd13;
  localparam logic [POS_W-1:0] POS_IHL          = 17'd14;
  localparam logic [POS_W-1:0] POS_TOTLEN_HI    = 17'd16;
  localparam logic [POS_W-1:0] POS_TOTLEN_LO    = 17'd17;
  localparam logic [POS_W-1:0] POS_PROTOCOL     = 17'd23;
  localparam logic [POS_W-1:0] TCP_OFFSET_BYTE  = 17'd12;

  localparam logic [3:0]  MIN_HDR_WORDS      = 4'd5;
  localparam logic [15:0] ETHERTYPE_RESET    = 16'h0800;
  localparam logic [7:0]  PROTOCOL_RESET     = 8'd6;
  localparam logic [7:0]  DOT_CHAR           = 8'h2E;
  localparam logic [7:0]  PRINT_LOW          = 8'h20;
  localparam logic [7:0]  PRINT_HIGH         = 8'h7E;

  // One result item.
  typedef struct packed {
    logic [7:0] shown_char;
    logic       last_of_payload;
    logic       cut_short;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/tcp_payload_extractor.sv -----
// Top level of the TCP payload extractor: header parse, payload filter and output buffer.
`default_nettype none

// The block takes an Ethernet frame one byte per transfer and emits the TCP payload bytes of
// IPv4/TCP frames, each non-printable byte shown as '.', with the last payload byte marked and
// a frame that ends inside its payload flagged as cut short. A new frame byte is taken in every
// unstalled cycle: each byte is parsed by counter compares against a 17-bit byte position and
// the captured header fields, and its result, if any, is written into the output or skid register.
// A two-entry output buffer (output register plus skid register) lets a byte be taken while a
// result still waits downstream; frame_stall_o rises only when both entries are full, so the
// sustained rate is one byte per cycle whenever the output side keeps up. The EtherType and
// IPv4 protocol to match are set through the APB port at byte addresses 0 and 4 and should be
// written only while the block is idle.
module tcp_payload_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Frame byte input channel
  input  wire logic        frame_valid_i,
  output logic             frame_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        end_of_frame_i,
  // Payload character output channel
  output logic             char_valid_o,
  input  wire logic        char_stall_i,
  output logic      [7:0]  shown_char_o,
  output logic             last_of_payload_o,
  output logic             cut_short_o
);

  localparam int unsigned PW = tpe_pkg::POS_W;

  // Configuration registers.
  logic [15:0] match_ethertype_q;
  logic [7:0]  match_protocol_q;

  // Parse state.
  tpe_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [7:0]      held_hi_q, held_hi_d;
  logic [3:0]      ip_words_q, ip_words_d;
  logic [15:0]     total_len_q, total_len_d;
  logic [3:0]      tcp_words_q, tcp_words_d;
  logic [PW-1:0]   pay_end_q, pay_end_d;

  // Output buffer.
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  tpe_pkg::result_t out_q, out_d;
  tpe_pkg::result_t skid_q, skid_d;

  logic             in_fire;
  logic             out_take;
  logic             emit;
  tpe_pkg::result_t res;

  logic [PW-1:0] tcp_start;
  logic [PW-1:0] pay_start;
  logic [PW-1:0] pay_start_new;
  logic [PW-1:0] pay_end_new;
  logic [3:0]    tcp_words_new;
  logic [PW:0]   pos_plus1;
  logic          is_last;
  logic          is_cut;
  logic          cfg_write;

  // ------------------------------------------------------------------
  // Configuration port. Only paddr[2] selects the register, so every
  // write lands on one of the two.
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (tpe_pkg::reg_idx_e'(paddr[2]))
      tpe_pkg::REG_ETHERTYPE: prdata = {16'd0, match_ethertype_q};
      tpe_pkg::REG_PROTOCOL:  prdata = {24'd0, match_protocol_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_ethertype_q <= tpe_pkg::ETHERTYPE_RESET;
      match_protocol_q  <= tpe_pkg::PROTOCOL_RESET;
    end else if (cfg_write) begin
      case (tpe_pkg::reg_idx_e'(paddr[2]))
        tpe_pkg::REG_ETHERTYPE: match_ethertype_q <= pwdata[15:0];
        tpe_pkg::REG_PROTOCOL:  match_protocol_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Handshakes. The input stalls only while the skid entry is occupied.
  // ------------------------------------------------------------------
  assign frame_stall_o = skid_valid_q;
  assign in_fire       = frame_valid_i && !skid_valid_q;
  assign out_take      = out_valid_q && !char_stall_i;

  // ------------------------------------------------------------------
  // Header offsets. The IHL and data offset are at most 15 words, so the
  // payload start stays far below the position range.
  // ------------------------------------------------------------------
  assign tcp_start     = tpe_pkg::ETH_HDR_BYTES + {{(PW-6){1'b0}}, ip_words_q, 2'b00};
  assign pay_start     = tcp_start + {{(PW-6){1'b0}}, tcp_words_q, 2'b00};
  assign tcp_words_new = frame_byte_i[7:4];
  assign pay_start_new = tcp_start + {{(PW-6){1'b0}}, tcp_words_new, 2'b00};
  assign pay_end_new   = tpe_pkg::ETH_HDR_BYTES + {{(PW-16){1'b0}}, total_len_q};
  assign pos_plus1     = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};
  assign is_last       = (pos_plus1 == {1'b0, pay_end_q});
  assign is_cut        = end_of_frame_i && !is_last;

  // Result for the current byte; only used when emit is set.
  always_comb begin
    res.shown_char = ((frame_byte_i >= tpe_pkg::PRINT_LOW) &&
                      (frame_byte_i <= tpe_pkg::PRINT_HIGH)) ? frame_byte_i
                                                             : tpe_pkg::DOT_CHAR;
    res.last_of_payload = is_last || is_cut;
    res.cut_short       = is_cut;
  end

  // ------------------------------------------------------------------
  // Parser next state.
  // ------------------------------------------------------------------
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    held_hi_d   = held_hi_q;
    ip_words_d  = ip_words_q;
    total_len_d = total_len_q;
    tcp_words_d = tcp_words_q;
    pay_end_d   = pay_end_q;
    emit        = 1'b0;

    if (in_fire) begin
      case (phase_q)
        tpe_pkg::PHASE_HEADER: begin
          if (pos_q == tpe_pkg::POS_ETYPE_HI || pos_q == tpe_pkg::POS_TOTLEN_HI) begin
            held_hi_d = frame_byte_i;
          end else if (pos_q == tpe_pkg::POS_ETYPE_LO) begin
            if ({held_hi_q, frame_byte_i} != match_ethertype_q) begin
              phase_d = tpe_pkg::PHASE_DROP;
            end
          end else if (pos_q == tpe_pkg::POS_IHL) begin
            ip_words_d = frame_byte_i[3:0];
            if (frame_byte_i[3:0] < tpe_pkg::MIN_HDR_WORDS) begin
              phase_d = tpe_pkg::PHASE_DROP;
            end
          end else if (pos_q == tpe_pkg::POS_TOTLEN_LO) begin
            total_len_d = {held_hi_q, frame_byte_i};
          end else if (pos_q == tpe_pkg::POS_PROTOCOL) begin
            if (frame_byte_i != match_protocol_q) begin
              phase_d = tpe_pkg::PHASE_DROP;
            end
          end else if (pos_q > tpe_pkg::POS_PROTOCOL &&
                       pos_q == tcp_start + tpe_pkg::TCP_OFFSET_BYTE) begin
            // The TCP data offset byte: the payload bounds are now known.
            tcp_words_d = tcp_words_new;
            pay_end_d   = pay_end_new;
            if (tcp_words_new < tpe_pkg::MIN_HDR_WORDS || pay_end_new <= pay_start_new) begin
              phase_d = tpe_pkg::PHASE_DROP;
            end else begin
              phase_d = tpe_pkg::PHASE_PAYLOAD;
            end
          end
        end
        tpe_pkg::PHASE_PAYLOAD: begin
          if (pos_q >= pay_start && pos_q < pay_end_q) begin
            emit = 1'b1;
            if (is_last) begin
              phase_d = tpe_pkg::PHASE_DROP;
            end
          end else if (pos_q >= pay_end_q) begin
            phase_d = tpe_pkg::PHASE_DROP;
          end
        end
        default: ;
      endcase

      // The end of a frame returns all parse state to its start values.
      if (end_of_frame_i) begin
        phase_d     = tpe_pkg::PHASE_HEADER;
        pos_d       = '0;
        held_hi_d   = '0;
        ip_words_d  = '0;
        total_len_d = '0;
        tcp_words_d = '0;
        pay_end_d   = '0;
      end else if (pos_q != tpe_pkg::POS_MAX) begin
        pos_d = pos_plus1[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tpe_pkg::PHASE_HEADER;
      pos_q       <= '0;
      held_hi_q   <= '0;
      ip_words_q  <= '0;
      total_len_q <= '0;
      tcp_words_q <= '0;
      pay_end_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      held_hi_q   <= held_hi_d;
      ip_words_q  <= ip_words_d;
      total_len_q <= total_len_d;
      tcp_words_q <= tcp_words_d;
      pay_end_q   <= pay_end_d;
    end
  end

  // ------------------------------------------------------------------
  // Output buffer. A new result goes to the output register when it is
  // free or being emptied this cycle, otherwise to the skid register. The
  // skid entry drains into the output register before new bytes are taken.
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign char_valid_o      = out_valid_q;
  assign shown_char_o      = out_q.shown_char;
  assign last_of_payload_o = out_q.last_of_payload;
  assign cut_short_o       = out_q.cut_short;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // The skid entry is only ever filled behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  // A cut-short byte always closes the payload of its frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (char_valid_o && cut_short_o) |-> last_of_payload_o)
    else $error("cut_short set without last_of_payload");

  // The end of a frame restarts the byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_fire && end_of_frame_i) |=> (pos_q == '0))
    else $error("byte position not cleared after the end of a frame");

  // The payload phase is entered only with a valid TCP data offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == tpe_pkg::PHASE_PAYLOAD) |-> (tcp_words_q >= tpe_pkg::MIN_HDR_WORDS))
    else $error("payload phase with a data offset below the minimum");

endmodule

`default_nettype wire
